/* design/lcw_pkg.sv */
// lcw_pkg: shared constants for the lcw frame decompressor
// status codes and command byte fields; no dependencies
package lcw_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_READ = 2'd0;
	localparam status_t ST_DONE = 2'd1;
	localparam status_t ST_OVF  = 2'd2;

	localparam logic [5:0] CNT_FILL = 6'h3E;
	localparam logic [5:0] CNT_COPY = 6'h3F;

endpackage

/* design/lcw_store.sv */
// lcw_store: frame byte store, one write port and one registered read port
// no package dependencies
module lcw_store #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* design/lcw_frame_decompressor.sv */
// lcw_frame_decompressor: top level, command parser and copy/fill sequencer
// uses lcw_pkg and lcw_store
//
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | func, code_byte, read_addr
// out     | output    | out_valid / out_stall  | status, pixel, frame_length
// cfg     | input     | cfg_wen                | cfg_wdata (frame_size)
//
// a read word passes through the E_READ state, then its result word waits for the out side
// a frame-end word raises a result word, and input stalls until that word is taken
// a back-copy or absolute copy moves each byte as a store read, then a write
// a fill writes each byte directly; all bytes go through the one store port pair
// no clearing pass: entries at or above the write pointer read as zero
// in_stall is high while a copy, fill or read runs and while a result waits
module lcw_frame_decompressor #(
	parameter int STORE_BYTES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [7:0]           code_byte,
	input  logic [15:0]          read_addr,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lcw_pkg::status_t     status,
	output logic [7:0]           pixel,
	output logic [16:0]          frame_length,
	input  logic                 cfg_wen,
	input  logic [16:0]          cfg_wdata
);
	import lcw_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [16:0] STORE_LEN = 17'(STORE_BYTES);

	typedef enum logic [3:0] {
		P_NEW, P_CMD, P_REL, P_LIT, P_ALO, P_AHI, P_FCLO, P_FCHI, P_FVAL,
		P_CCLO, P_CCHI, P_CSLO, P_CSHI
	} phase_t;

	typedef enum logic [2:0] {
		E_IDLE, E_READ, E_CRD, E_CWR, E_FILL
	} exec_t;

	phase_t      phase_q;
	exec_t       exec_q;
	logic [7:0]  cmd_q;
	logic [15:0] run_q;
	logic [AW-1:0] src_q;
	logic [7:0]  lo_q;
	logic [16:0] dest_q;
	logic [7:0]  fill_q;
	logic [16:0] size_q;
	logic        vld_s1;
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  pixel_q;
	logic [16:0] len_q;

	logic          acc;
	logic          mem_we;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic [16:0]   eff_size;
	logic [16:0]   dest_n;
	logic [16:0]   rd_ext;
	logic [16:0]   src_ext;
	logic [11:0]   rel_n;
	logic [AW+11:0] rel_w;
	logic [15:0]   src16;

	assign in_stall     = (exec_q != E_IDLE) || out_valid_q;
	assign acc          = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign pixel        = pixel_q;
	assign frame_length = len_q;

	assign eff_size = (size_q > STORE_LEN) ? STORE_LEN : size_q;
	assign dest_n   = (phase_q == P_NEW) ? 17'd0 : dest_q;
	assign rd_ext   = {{(17-AW){1'b0}}, read_addr[AW-1:0]};
	assign src_ext  = {{(17-AW){1'b0}}, src_q};
	assign rel_n    = {cmd_q[3:0], code_byte};
	assign rel_w    = {{AW{1'b0}}, rel_n};
	assign src16    = {code_byte, lo_q};

	function automatic logic ovf(input logic [16:0] d, input logic [15:0] cnt,
			input logic [16:0] lim);
		logic [17:0] sum;
		sum = {1'b0, d} + {2'b0, cnt};
		return sum > {1'b0, lim};
	endfunction

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = code_byte;
		case (exec_q)
			E_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = fill_q;
			end
			E_CWR: begin
				mem_we    = 1'b1;
				mem_wdata = vld_s1 ? mem_rdata : 8'd0;
			end
			default: begin
				mem_we = acc && !func && (phase_q == P_LIT);
			end
		endcase
		mem_raddr = (exec_q == E_CRD) ? src_q : read_addr[AW-1:0];
	end

	lcw_store #(.AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (dest_q[AW-1:0]),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_NEW;
			exec_q      <= E_IDLE;
			cmd_q       <= '0;
			run_q       <= '0;
			src_q       <= '0;
			lo_q        <= '0;
			dest_q      <= '0;
			fill_q      <= '0;
			size_q      <= 17'h10000;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_READ;
			pixel_q     <= '0;
			len_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wen) begin
				size_q <= cfg_wdata;
			end
			unique case (exec_q)
				E_IDLE: begin
					if (acc && func) begin
						vld_s1 <= rd_ext < dest_q;
						exec_q <= E_READ;
					end else if (acc) begin
						unique case (phase_q)
							P_REL: begin
								phase_q <= P_CMD;
								if (ovf(dest_q, run_q, eff_size)) begin
									out_valid_q <= 1'b1;
									status_q    <= ST_OVF;
									pixel_q     <= '0;
									len_q       <= dest_q;
									phase_q     <= P_NEW;
								end else begin
									src_q  <= dest_q[AW-1:0] - rel_w[AW-1:0];
									exec_q <= E_CRD;
								end
							end
							P_LIT: begin
								dest_q <= dest_q + 17'd1;
								run_q  <= run_q - 16'd1;
								if (run_q == 16'd1) begin
									phase_q <= P_CMD;
								end
							end
							P_ALO, P_CSLO: begin
								lo_q    <= code_byte;
								phase_q <= (phase_q == P_ALO) ? P_AHI : P_CSHI;
							end
							P_AHI, P_CSHI: begin
								src_q   <= src16[AW-1:0];
								phase_q <= P_CMD;
								if (ovf(dest_q, run_q, eff_size)) begin
									out_valid_q <= 1'b1;
									status_q    <= ST_OVF;
									pixel_q     <= '0;
									len_q       <= dest_q;
									phase_q     <= P_NEW;
								end else if (run_q != 16'd0) begin
									exec_q <= E_CRD;
								end
							end
							P_FCLO, P_CCLO: begin
								run_q   <= {8'd0, code_byte};
								phase_q <= (phase_q == P_FCLO) ? P_FCHI : P_CCHI;
							end
							P_FCHI, P_CCHI: begin
								run_q[15:8] <= code_byte;
								phase_q     <= (phase_q == P_FCHI) ? P_FVAL : P_CSLO;
							end
							P_FVAL: begin
								fill_q  <= code_byte;
								phase_q <= P_CMD;
								if (ovf(dest_q, run_q, eff_size)) begin
									out_valid_q <= 1'b1;
									status_q    <= ST_OVF;
									pixel_q     <= '0;
									len_q       <= dest_q;
									phase_q     <= P_NEW;
								end else if (run_q != 16'd0) begin
									exec_q <= E_FILL;
								end
							end
							default: begin
								// command word; a new frame restarts the write pointer
								dest_q <= dest_n;
								cmd_q  <= code_byte;
								if (!code_byte[7]) begin
									run_q   <= {13'd0, code_byte[6:4]} + 16'd3;
									phase_q <= P_REL;
								end else if (!code_byte[6]) begin
									if (code_byte[5:0] == 6'd0) begin
										out_valid_q <= 1'b1;
										status_q    <= ST_DONE;
										pixel_q     <= '0;
										len_q       <= dest_n;
										phase_q     <= P_NEW;
									end else if (ovf(dest_n, {10'd0, code_byte[5:0]},
											eff_size)) begin
										out_valid_q <= 1'b1;
										status_q    <= ST_OVF;
										pixel_q     <= '0;
										len_q       <= dest_n;
										phase_q     <= P_NEW;
									end else begin
										run_q   <= {10'd0, code_byte[5:0]};
										phase_q <= P_LIT;
									end
								end else if (code_byte[5:0] == CNT_FILL) begin
									phase_q <= P_FCLO;
								end else if (code_byte[5:0] == CNT_COPY) begin
									phase_q <= P_CCLO;
								end else begin
									run_q   <= {10'd0, code_byte[5:0]} + 16'd3;
									phase_q <= P_ALO;
								end
							end
						endcase
					end
				end
				E_READ: begin
					out_valid_q <= 1'b1;
					status_q    <= ST_READ;
					pixel_q     <= vld_s1 ? mem_rdata : 8'd0;
					len_q       <= '0;
					exec_q      <= E_IDLE;
				end
				E_CRD: begin
					vld_s1 <= src_ext < dest_q;
					exec_q <= E_CWR;
				end
				E_CWR: begin
					dest_q <= dest_q + 17'd1;
					src_q  <= src_q + 1'b1;
					run_q  <= run_q - 16'd1;
					exec_q <= (run_q == 16'd1) ? E_IDLE : E_CRD;
				end
				E_FILL: begin
					dest_q <= dest_q + 17'd1;
					run_q  <= run_q - 16'd1;
					exec_q <= (run_q == 16'd1) ? E_IDLE : E_FILL;
				end
				default: begin
					exec_q <= E_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cwr_after_crd: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q == E_CWR |-> $past(exec_q) == E_CRD)
		else $error("copy write without store read");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_q == E_FILL || exec_q == E_CRD || exec_q == E_CWR) |-> run_q != 16'd0)
		else $error("copy or fill running with zero count");

	a_read_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_READ |-> len_q == 17'd0)
		else $error("read word carries a length");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(exec_q == E_READ) |-> $past(acc && func))
		else $error("read started without an accepted read word");
`endif

endmodule
